### rtl/pulse_duration_uart_frame_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef PULSE_DURATION_UART_FRAME_DECODER_UNIT_DEFINES_SVH
`define PULSE_DURATION_UART_FRAME_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pdu_pkg.sv
package pdu_pkg;

    // Frame layout: start bit, eight data bits LSB first, even parity, stop bit.
    localparam int FRAME_BITS = 11;
    localparam int DATA_BITS  = 8;
    localparam int START_BIT  = 0;
    localparam int STOP_BIT   = 10;

    // Datapath widths.
    localparam int TICK_W        = 12;
    localparam int BYTES_W       = 6;
    localparam int BITS_W        = 4;
    localparam int LIMIT_W       = 16;
    localparam int EDGE_KEEP_W   = 18;
    localparam int EDGE_W        = 19;
    localparam int SAMPLE_KEEP_W = 16;
    localparam int SAMPLE_W      = 17;
    localparam int STATUS_W      = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TICKS     = 2'd0,
        CFG_SAMPLE_OFFSET = 2'd1,
        CFG_MAX_BYTES     = 2'd2,
        CFG_MIN_BYTES     = 2'd3
    } cfg_idx_t;

    // Reset values, derived from a 4 MHz tick and 9600 baud.
    localparam int TICK_HZ   = 4000000;
    localparam int LINE_BAUD = 9600;
    localparam logic [TICK_W-1:0]  RST_BIT_TICKS     = TICK_W'(TICK_HZ / LINE_BAUD);
    localparam logic [TICK_W-1:0]  RST_SAMPLE_OFFSET = TICK_W'(TICK_HZ / LINE_BAUD / 2 / 3);
    localparam logic [BYTES_W-1:0] RST_MAX_BYTES     = BYTES_W'(32);
    localparam logic [BYTES_W-1:0] RST_MIN_BYTES     = BYTES_W'(3);

    // Packet status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD   = 3'd0,
        ST_SHORT  = 3'd1,
        ST_START  = 3'd2,
        ST_STOP   = 3'd3,
        ST_PARITY = 3'd4,
        ST_MANY   = 3'd5,
        ST_LONG   = 3'd6
    } status_t;

    // Verdict on one completed frame.
    typedef struct packed {
        logic                 fail;
        status_t              status;
        logic [DATA_BITS-1:0] data_byte;
        logic [BYTES_W-1:0]   bytes_next;
    } check_t;

endpackage

### rtl/pdu_intf.sv
// Pulse request channel: one captured low/high pulse pair.
interface pdu_pulse_if #(
    parameter int DURATION_BITS = 15
) ();
    logic                     valid;
    logic                     ready;
    logic [DURATION_BITS-1:0] low_ticks;
    logic [DURATION_BITS-1:0] high_ticks;
    logic                     is_last;

    modport source (output valid, output low_ticks, output high_ticks, output is_last,
                    input ready);
    modport sink   (input valid, input low_ticks, input high_ticks, input is_last,
                    output ready);
endinterface

// Result channel: one decoded byte or packet close.
interface pdu_result_if ();
    logic                             valid;
    logic                             ready;
    logic [pdu_pkg::DATA_BITS-1:0]    byte_value;
    logic                             byte_valid;
    logic                             packet_end;
    logic [pdu_pkg::STATUS_W-1:0]     packet_status;

    modport source (output valid, output byte_value, output byte_valid,
                    output packet_end, output packet_status, input ready);
    modport sink   (input valid, input byte_value, input byte_valid,
                    input packet_end, input packet_status, output ready);
endinterface

// Configuration write channel.
interface pdu_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [pdu_pkg::CFG_IDX_W-1:0]     index;
    logic [pdu_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pdu_frame_check.sv
module pdu_frame_check (
    input  logic [pdu_pkg::FRAME_BITS-1:0] frame,
    input  logic [pdu_pkg::BYTES_W-1:0]    bytes_taken,
    input  logic [pdu_pkg::BYTES_W-1:0]    max_bytes,
    input  logic [pdu_pkg::BYTES_W-1:0]    min_bytes,
    input  logic                           is_last,
    output pdu_pkg::check_t                check
);
    import pdu_pkg::*;

    logic [BYTES_W-1:0] bytes_inc;

    assign bytes_inc = bytes_taken + BYTES_W'(1);

    // Frame checks in priority order, then the byte limit and the packet length.
    always_comb
    begin
        check            = '0;
        check.data_byte  = frame[START_BIT+1 +: DATA_BITS];
        check.status     = ST_GOOD;
        check.bytes_next = '0;
        priority if (frame[START_BIT])
        begin
            check.fail   = 1'b1;
            check.status = ST_START;
        end
        else if (!frame[STOP_BIT])
        begin
            check.fail   = 1'b1;
            check.status = ST_STOP;
        end
        else if (!(^frame))
        begin
            check.fail   = 1'b1;
            check.status = ST_PARITY;
        end
        else if (bytes_inc >= max_bytes)
        begin
            check.fail   = 1'b1;
            check.status = ST_MANY;
        end
        else if (is_last)
        begin
            check.status = (bytes_inc >= min_bytes) ? ST_GOOD : ST_SHORT;
        end
        else
        begin
            check.bytes_next = bytes_inc;
        end
    end

endmodule

### rtl/pulse_duration_uart_frame_decoder_unit.sv
// UART 8E1 receiver that works on captured line pulses. Each request on the
// pulse channel carries the low and the high duration of one pulse in timer
// ticks; the block rebuilds 11-bit frames by sampling each bit slot
// sample_offset ticks after it begins and gives at most one result per pulse:
// a good byte, or a packet close with its status. A high part of zero or the
// last pulse pads the frame with idle-high bits. After an error, pulses are
// dropped up to and including the next last pulse. Pulses are handled one at
// a time. A dropped pulse goes from the prepare state straight back to idle.
// A pulse that is too long, or whose sampling point already lies past the
// frame, goes from prepare to finish. Any other pulse passes prepare, the
// sampling of the low part, the high step, the padding step when the frame
// is padded, the sampling of the high part and finish. A single shared adder
// advances the sampling point by one bit slot per cycle, and at most 11 bits
// are sampled during one pulse. A finished result waits in an output
// register, so the next pulse is accepted while it is still pending; the
// block stalls only when a second result is due before the first is taken.
// Configuration writes are taken in any cycle and act at once.
module pulse_duration_uart_frame_decoder_unit #(
    parameter int DURATION_BITS = 15
) (
    input  logic         clk,
    input  logic         rst_n,
    pdu_cfg_if.sink      cfg,
    pdu_pulse_if.sink    pulse,
    pdu_result_if.source result
);
    import pdu_pkg::*;

    `include "pulse_duration_uart_frame_decoder_unit_defines.svh"

    localparam int CMP_W = (DURATION_BITS > LIMIT_W) ? DURATION_BITS : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_BITS0,
        S_HIGH,
        S_PAD,
        S_BITS1,
        S_FINISH
    } state_t;

    // Configuration registers.
    logic [TICK_W-1:0]  bit_ticks_reg;
    logic [TICK_W-1:0]  sample_offset_reg;
    logic [BYTES_W-1:0] max_bytes_reg;
    logic [BYTES_W-1:0] min_bytes_reg;

    // Sequencer and decoder state.
    state_t                   state_reg, state_next;
    logic [EDGE_W-1:0]        edge_reg, edge_next;
    logic [SAMPLE_W-1:0]      sample_reg, sample_next;
    logic [FRAME_BITS-1:0]    shift_reg, shift_next;
    logic [BITS_W-1:0]        bits_reg, bits_next;
    logic [BYTES_W-1:0]       bytes_reg, bytes_next;
    logic                     dropping_reg, dropping_next;
    logic [DURATION_BITS-1:0] low_reg, low_next;
    logic [DURATION_BITS-1:0] high_reg, high_next;
    logic                     last_reg, last_next;
    logic                     long_reg, long_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_BITS-1:0] out_byte_reg, out_byte_next;
    logic                 out_bvalid_reg, out_bvalid_next;
    logic                 out_end_reg, out_end_next;
    status_t              out_status_reg, out_status_next;

    // Derived values.
    logic [TICK_W-1:0]   step;
    logic [LIMIT_W-1:0]  limit;
    logic [SAMPLE_W-1:0] sample_eff;
    logic                too_long;
    logic                take_bit;
    logic                pad;
    logic                complete;
    logic                out_free;
    logic [EDGE_W-1:0]   add_a;
    logic [EDGE_W-1:0]   add_b;
    logic [EDGE_W-1:0]   add_sum;
    check_t              check;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg     <= RST_BIT_TICKS;
            sample_offset_reg <= RST_SAMPLE_OFFSET;
            max_bytes_reg     <= RST_MAX_BYTES;
            min_bytes_reg     <= RST_MIN_BYTES;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_BIT_TICKS:     bit_ticks_reg     <= cfg.data;
                CFG_SAMPLE_OFFSET: sample_offset_reg <= cfg.data;
                CFG_MAX_BYTES:     max_bytes_reg     <= cfg.data[BYTES_W-1:0];
                CFG_MIN_BYTES:     min_bytes_reg     <= cfg.data[BYTES_W-1:0];
            endcase
        end
    end

    // Bit pitch (zero acts as one) and the length of a whole frame.
    assign step  = (bit_ticks_reg == '0) ? TICK_W'(1) : bit_ticks_reg;
    assign limit = LIMIT_W'(step) * LIMIT_W'(FRAME_BITS);

    // Sampling point, reloaded when a new frame starts.
    assign sample_eff = (edge_reg == '0) ? SAMPLE_W'(sample_offset_reg) : sample_reg;

    assign too_long = (CMP_W'(low_reg) > CMP_W'(limit)) ||
                      (CMP_W'(high_reg) > CMP_W'(limit));
    assign take_bit = (EDGE_W'(sample_reg) < edge_reg) &&
                      (bits_reg < BITS_W'(FRAME_BITS));
    assign pad      = last_reg || (high_reg == '0);
    assign complete = (sample_reg[SAMPLE_KEEP_W-1:0] >= limit) || last_reg;
    assign out_free = !out_valid_reg || result.ready;

    // Shared adder: line time and sampling point advance through it.
    always_comb
    begin
        unique case (state_reg)
            S_PREP:
            begin
                add_a = edge_reg;
                add_b = EDGE_W'(low_reg);
            end
            S_BITS0, S_BITS1:
            begin
                add_a = EDGE_W'(sample_reg);
                add_b = EDGE_W'(step);
            end
            S_HIGH:
            begin
                add_a = edge_reg;
                add_b = EDGE_W'(high_reg);
            end
            S_PAD:
            begin
                add_a = edge_reg;
                add_b = EDGE_W'(limit);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    pdu_frame_check u_check (
        .frame       (shift_reg),
        .bytes_taken (bytes_reg),
        .max_bytes   (max_bytes_reg),
        .min_bytes   (min_bytes_reg),
        .is_last     (last_reg),
        .check       (check)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        edge_next       = edge_reg;
        sample_next     = sample_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        bytes_next      = bytes_reg;
        dropping_next   = dropping_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        last_next       = last_reg;
        long_next       = long_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pulse.valid)
                begin
                    low_next   = pulse.low_ticks;
                    high_next  = pulse.high_ticks;
                    last_next  = pulse.is_last;
                    long_next  = 1'b0;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                if (dropping_reg)
                begin
                    if (last_reg)
                    begin
                        dropping_next = 1'b0;
                        edge_next     = '0;
                        shift_next    = '0;
                        bits_next     = '0;
                        bytes_next    = '0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    sample_next = sample_eff;
                    if (too_long)
                    begin
                        long_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else if (sample_eff < SAMPLE_W'(limit))
                    begin
                        edge_next  = add_sum;
                        state_next = S_BITS0;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            // Bits sampled during the low part shift in as zero.
            S_BITS0:
            begin
                if (take_bit)
                begin
                    sample_next = add_sum[SAMPLE_W-1:0];
                    shift_next  = {1'b0, shift_reg[FRAME_BITS-1:1]};
                    bits_next   = bits_reg + BITS_W'(1);
                end
                else
                begin
                    state_next = S_HIGH;
                end
            end

            S_HIGH:
            begin
                edge_next  = add_sum;
                state_next = pad ? S_PAD : S_BITS1;
            end

            // Idle-high padding of one whole frame.
            S_PAD:
            begin
                edge_next  = add_sum;
                state_next = S_BITS1;
            end

            // Bits sampled during the high part shift in as one.
            S_BITS1:
            begin
                if (take_bit)
                begin
                    sample_next = add_sum[SAMPLE_W-1:0];
                    shift_next  = {1'b1, shift_reg[FRAME_BITS-1:1]};
                    bits_next   = bits_reg + BITS_W'(1);
                end
                else
                begin
                    edge_next   = {1'b0, edge_reg[EDGE_KEEP_W-1:0]};
                    sample_next = {1'b0, sample_reg[SAMPLE_KEEP_W-1:0]};
                    state_next  = S_FINISH;
                end
            end

            // Close a finished or over-long frame into the output register when it is free.
            S_FINISH:
            begin
                if (!long_reg && !complete)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    edge_next      = '0;
                    shift_next     = '0;
                    bits_next      = '0;
                    out_valid_next = 1'b1;
                    if (long_reg || check.fail)
                    begin
                        out_byte_next   = '0;
                        out_bvalid_next = 1'b0;
                        out_end_next    = 1'b1;
                        out_status_next = long_reg ? ST_LONG : check.status;
                        bytes_next      = '0;
                        dropping_next   = !last_reg;
                    end
                    else
                    begin
                        out_byte_next   = check.data_byte;
                        out_bvalid_next = 1'b1;
                        out_end_next    = last_reg;
                        out_status_next = check.status;
                        bytes_next      = check.bytes_next;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_reg       <= '0;
            sample_reg     <= SAMPLE_W'(RST_SAMPLE_OFFSET);
            shift_reg      <= '0;
            bits_reg       <= '0;
            bytes_reg      <= '0;
            dropping_reg   <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            last_reg       <= 1'b0;
            long_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_bvalid_reg <= 1'b0;
            out_end_reg    <= 1'b0;
            out_status_reg <= ST_GOOD;
        end
        else
        begin
            state_reg      <= state_next;
            edge_reg       <= edge_next;
            sample_reg     <= sample_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            bytes_reg      <= bytes_next;
            dropping_reg   <= dropping_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            last_reg       <= last_next;
            long_reg       <= long_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_bvalid_reg <= out_bvalid_next;
            out_end_reg    <= out_end_next;
            out_status_reg <= out_status_next;
        end
    end

    assign pulse.ready          = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.byte_value    = out_byte_reg;
    assign result.byte_valid    = out_bvalid_reg;
    assign result.packet_end    = out_end_reg;
    assign result.packet_status = out_status_reg;

    // Between pulses the line time and sampling point are wrapped and the bit count is bounded.
    `PDU_ASSERT_IMPLY(a_idle_wrapped, clk, rst_n, state_reg == S_IDLE, edge_reg[EDGE_W-1] == 1'b0 && sample_reg[SAMPLE_W-1] == 1'b0 && bits_reg <= BITS_W'(FRAME_BITS), "state not wrapped between pulses")

    // A result without a byte always closes the packet with an error.
    `PDU_ASSERT_IMPLY(a_error_closes, clk, rst_n, result.valid && !result.byte_valid, result.packet_end && result.packet_status != ST_GOOD && result.byte_value == '0, "error result malformed")

    // A result that does not close the packet carries a good byte.
    `PDU_ASSERT_IMPLY(a_open_is_byte, clk, rst_n, result.valid && !result.packet_end, result.byte_valid && result.packet_status == ST_GOOD, "open result without byte")

    // An accepted pulse keeps the block busy in the next cycle.
    `PDU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, pulse.valid && pulse.ready, !pulse.ready, "ready right after a request")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import pdu_pkg::*;

    localparam int          DUR_W         = 15;
    localparam int unsigned DUR_MAX       = (1 << DUR_W) - 1;
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_PULSES = 1450;

    // One decoded result as the block presents it.
    typedef struct packed {
        logic [DATA_BITS-1:0] byte_value;
        logic                 byte_valid;
        logic                 packet_end;
        status_t              status;
    } byte_result_t;

    typedef struct {
        int unsigned bt;
        int unsigned off;
        int unsigned mx;
        int unsigned mn;
    } timing_t;

    logic clk;
    logic rst_n;

    pdu_pulse_if #(.DURATION_BITS(DUR_W)) pulse_ch ();
    pdu_result_if                         result_ch ();
    pdu_cfg_if                            cfg_ch ();

    pulse_duration_uart_frame_decoder_unit #(
        .DURATION_BITS (DUR_W)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pulse  (pulse_ch),
        .result (result_ch)
    );

    // Decoder state mirrored by the testbench.
    logic [TICK_W-1:0]  bit_ticks_r;
    logic [TICK_W-1:0]  offset_r;
    logic [BYTES_W-1:0] max_r;
    logic [BYTES_W-1:0] min_r;
    int unsigned        edge_r;
    int unsigned        sample_r;
    logic [10:0]        shift_r;
    int unsigned        nbits_r;
    logic [BYTES_W-1:0] nbytes_r;
    bit                 dropping_r;

    byte_result_t pending_bytes[$];
    bit           line_q[$];
    int unsigned  pulses_sent = 0;
    int unsigned  errors = 0;
    bit           steady = 0;
    bit           jitter_on = 0;
    bit           hold_request = 0;
    int unsigned  hold_left = 0;
    int unsigned  stall_left = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Samples the line at every sampling point that the edge has passed.
    function automatic void shift_in(input int unsigned step, input bit level);
        while (sample_r < edge_r && nbits_r < FRAME_BITS)
        begin
            sample_r += step;
            shift_r   = {level, shift_r[10:1]};
            nbits_r++;
        end
    endfunction

    // Closes the packet on an error and starts dropping unless it was the last pulse.
    function automatic bit close_packet(output byte_result_t res, input status_t st,
                                        input bit last);
        res            = '0;
        res.packet_end = 1'b1;
        res.status     = st;
        edge_r         = 0;
        shift_r        = '0;
        nbits_r        = 0;
        nbytes_r       = '0;
        dropping_r     = !last;
        return 1'b1;
    endfunction

    // Works out the result, if any, that one pulse request causes.
    function automatic bit decode_pulse(input int unsigned low, input int unsigned high,
                                        input bit last, output byte_result_t res);
        int unsigned step;
        int unsigned limit;
        logic [10:0] frame;
        res   = '0;
        step  = (bit_ticks_r == 0) ? 1 : bit_ticks_r;
        limit = step * FRAME_BITS;

        if (dropping_r)
        begin
            if (last)
            begin
                dropping_r = 1'b0;
                edge_r     = 0;
                shift_r    = '0;
                nbits_r    = 0;
                nbytes_r   = '0;
            end
            return 1'b0;
        end

        if (edge_r == 0)
            sample_r = offset_r;
        if (low > limit || high > limit)
            return close_packet(res, ST_LONG, last);

        if (sample_r < limit)
        begin
            edge_r += low;
            shift_in(step, 1'b0);
            edge_r += high;
            if (last || high == 0)
                edge_r += limit;
            shift_in(step, 1'b1);
        end
        edge_r   &= 32'h3FFFF;
        sample_r &= 32'hFFFF;

        if (sample_r < limit && !last)
            return 1'b0;

        frame   = shift_r;
        edge_r  = 0;
        shift_r = '0;
        nbits_r = 0;

        if (frame[START_BIT])
            return close_packet(res, ST_START, last);
        if (!frame[STOP_BIT])
            return close_packet(res, ST_STOP, last);
        if ($countones(frame) % 2 == 0)
            return close_packet(res, ST_PARITY, last);

        nbytes_r = nbytes_r + 1'b1;
        if (nbytes_r >= max_r)
            return close_packet(res, ST_MANY, last);

        res.byte_value = frame[DATA_BITS:1];
        res.byte_valid = 1'b1;
        if (last)
        begin
            res.packet_end = 1'b1;
            res.status     = (nbytes_r >= min_r) ? ST_GOOD : ST_SHORT;
            nbytes_r       = '0;
        end
        return 1'b1;
    endfunction

    function automatic logic [10:0] encode_frame(input logic [7:0] b);
        return {1'b1, ^b, b, 1'b0};
    endfunction

    // Adds a little timing jitter to a tick count when enabled and clamps it to the duration field.
    function automatic int unsigned spread(input int unsigned ticks, input int unsigned step);
        int unsigned j;
        if (jitter_on && ticks != 0)
        begin
            j = $urandom_range(0, step / 10);
            if ($urandom_range(0, 1) != 0)
                ticks += j;
            else
                ticks = (ticks > j) ? ticks - j : 0;
        end
        return (ticks > DUR_MAX) ? DUR_MAX : ticks;
    endfunction

    // Offers one pulse request and records what it should produce once accepted.
    task automatic send_pulse(input int unsigned low, input int unsigned high, input bit last);
        byte_result_t res;
        int unsigned  gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            pulse_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pulse_ch.low_ticks  = DUR_W'(low);
        pulse_ch.high_ticks = DUR_W'(high);
        pulse_ch.is_last    = last;
        pulse_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (pulse_ch.ready !== 1'b1);
        if (decode_pulse(low, high, last, res))
            pending_bytes.push_back(res);
        pulses_sent++;
    endtask

    // Stops offering requests and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge clk);
        pulse_ch.valid = 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_BIT_TICKS:     bit_ticks_r = value;
            CFG_SAMPLE_OFFSET: offset_r    = value;
            CFG_MAX_BYTES:     max_r       = value[BYTES_W-1:0];
            CFG_MIN_BYTES:     min_r       = value[BYTES_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Writes all four registers once the block is idle. The byte limits get
    // random upper bits, which the block must ignore.
    task automatic configure(input int unsigned bt, input int unsigned off,
                             input int unsigned mx, input int unsigned mn);
        wait_drained();
        write_reg(CFG_BIT_TICKS, CFG_DATA_W'(bt));
        write_reg(CFG_SAMPLE_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_MAX_BYTES, {6'($urandom), 6'(mx)});
        write_reg(CFG_MIN_BYTES, {6'($urandom), 6'(mn)});
    endtask

    task automatic queue_frame(input logic [10:0] fr, input int unsigned idle);
        int unsigned i;
        for (i = 0; i < FRAME_BITS; i++)
            line_q.push_back(fr[i]);
        repeat (idle) line_q.push_back(1'b1);
    endtask

    // Cuts the queued line levels into low/high pulses and sends them as one packet.
    task automatic send_line(input bit timeouts);
        int unsigned step;
        int unsigned nlow;
        int unsigned nhigh;
        int unsigned lt;
        int unsigned ht;
        step = (bit_ticks_r == 0) ? 1 : bit_ticks_r;
        while (line_q.size() != 0)
        begin
            nlow  = 0;
            nhigh = 0;
            while (line_q.size() != 0 && line_q[0] == 1'b0)
            begin
                nlow++;
                void'(line_q.pop_front());
            end
            while (line_q.size() != 0 && line_q[0] == 1'b1)
            begin
                nhigh++;
                void'(line_q.pop_front());
            end
            lt = spread(nlow * step, step);
            ht = spread(nhigh * step, step);
            if (timeouts && line_q.size() != 0 && $urandom_range(0, 24) == 0)
                ht = 0;
            send_pulse(lt, ht, line_q.size() == 0);
        end
    endtask

    // One random packet: mostly well-formed frames, some corrupted or cut
    // short, and now and then bare noise pulses.
    task automatic random_burst();
        int unsigned r;
        int unsigned q;
        int unsigned nbytes;
        int unsigned i;
        int unsigned idx;
        int unsigned lim;
        logic [7:0]  b;
        logic [10:0] fr;
        r      = $urandom_range(0, 99);
        steady = ($urandom_range(0, 9) == 0);
        if (r < 10)
        begin
            lim = ((bit_ticks_r == 0) ? 1 : bit_ticks_r) * FRAME_BITS;
            if (lim > DUR_MAX)
                lim = DUR_MAX;
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) != 0)
                    send_pulse($urandom_range(0, DUR_MAX), $urandom_range(0, DUR_MAX),
                               $urandom_range(0, 3) == 0);
                else
                    send_pulse($urandom_range(0, lim), $urandom_range(0, lim),
                               $urandom_range(0, 3) == 0);
            end
        end
        else
        begin
            q = $urandom_range(0, 19);
            if (q < 16)
                nbytes = $urandom_range(1, 6);
            else if (q < 19)
                nbytes = $urandom_range(7, 16);
            else
                nbytes = max_r + $urandom_range(0, 2);
            if (nbytes == 0)
                nbytes = 1;
            for (i = 0; i < nbytes; i++)
            begin
                q = $urandom_range(0, 9);
                b = (q == 0) ? 8'h00 : (q == 1) ? 8'hFF : 8'($urandom);
                fr = encode_frame(b);
                if ($urandom_range(0, 19) == 0)
                begin
                    idx     = $urandom_range(0, FRAME_BITS - 1);
                    fr[idx] = ~fr[idx];
                end
                queue_frame(fr, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            end
            // Truncate the final frame so that the padding has to finish it.
            if (r < 20)
                repeat ($urandom_range(1, 10))
                    if (line_q.size() > 1)
                        void'(line_q.pop_back());
            send_line(1'b1);
        end
    endtask

    // Field extremes and each error path, with exact timing.
    task automatic test_directed();
        int unsigned bt;
        bt        = RST_BIT_TICKS;
        jitter_on = 1'b0;

        // A good packet of three bytes at the reset timing.
        queue_frame(encode_frame(8'h00), 0);
        queue_frame(encode_frame(8'hFF), 0);
        queue_frame(encode_frame(8'hA5), 2);
        send_line(1'b0);

        // An over-long low part, then pulses dropped up to the last one.
        send_pulse(DUR_MAX, 0, 1'b0);
        send_pulse(100, 200, 1'b0);
        send_pulse(0, DUR_MAX, 1'b1);

        // An over-long high part on the last pulse itself.
        send_pulse(5 * bt, FRAME_BITS * bt + 1, 1'b1);

        // Start bit seen high.
        send_pulse(0, 5 * bt, 1'b1);

        // A low part of exactly eleven slots leaves the stop bit low.
        send_pulse(FRAME_BITS * bt, 0, 1'b1);

        // Parity bit flipped.
        queue_frame(encode_frame(8'h0F) ^ 11'h200, 1);
        send_line(1'b0);

        // One good byte is fewer than the minimum.
        queue_frame(encode_frame(8'h00), 0);
        send_line(1'b0);

        // Idle timeout in the middle of a packet.
        send_pulse(10 * bt, 0, 1'b0);
        send_pulse(10 * bt, bt, 1'b1);

        // The second byte reaches the byte limit.
        configure(RST_BIT_TICKS, RST_SAMPLE_OFFSET, 2, RST_MIN_BYTES);
        send_pulse(10 * bt, bt, 1'b0);
        send_pulse(10 * bt, bt, 1'b1);

        // A bit length of zero counts as one tick.
        configure(0, 0, RST_MAX_BYTES, RST_MIN_BYTES);
        send_pulse(10, 1, 1'b1);

        // Sampling point beyond the whole frame: no bit is taken.
        configure(1, 4095, RST_MAX_BYTES, RST_MIN_BYTES);
        send_pulse(3, 3, 1'b1);

        // Sampling point past the first slot: every bit is sampled one slot late.
        configure(4, 5, RST_MAX_BYTES, RST_MIN_BYTES);
        send_pulse(8, 30, 1'b1);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block backs up and stalls its input.
    task automatic test_result_backlog();
        int unsigned i;
        configure(64, 32, 63, 0);
        jitter_on = 1'b1;
        steady    = 1'b1;
        @(posedge clk);
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            send_pulse(10 * 64, 64, (i % 8) == 7);
        wait_drained();
        steady = 1'b0;
    endtask

    // Random packets under a series of timings, the extremes among them.
    task automatic test_random_traffic();
        timing_t     plan[$];
        int unsigned bt;
        int unsigned first;
        plan.push_back('{416, 69, 32, 3});
        plan.push_back('{16, 8, 63, 0});
        plan.push_back('{1, 0, 5, 2});
        plan.push_back('{4095, 2047, 1, 63});
        plan.push_back('{0, 0, 0, 0});
        plan.push_back('{100, 4095, 20, 1});
        plan.push_back('{100, 150, 20, 1});
        plan.push_back('{200, 100, 63, 63});
        plan.push_back('{37, 18, 12, 4});
        bt = $urandom_range(2, 600);
        plan.push_back('{bt, bt / 2, $urandom_range(1, 63), $urandom_range(0, 63)});
        bt = $urandom_range(2, 2900);
        plan.push_back('{bt, $urandom_range(0, bt), $urandom_range(1, 63), $urandom_range(0, 8)});
        jitter_on = 1'b1;
        foreach (plan[k])
        begin
            configure(plan[k].bt, plan[k].off, plan[k].mx, plan[k].mn);
            first = pulses_sent;
            while (pulses_sent - first < RANDOM_PULSES / plan.size())
                random_burst();
        end
        steady = 1'b0;
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                stall_left      = pick_gap();
            end
        end
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        byte_result_t got;
        byte_result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.byte_value = result_ch.byte_value;
            got.byte_valid = result_ch.byte_valid;
            got.packet_end = result_ch.packet_end;
            got.status     = status_t'(result_ch.packet_status);
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected result: byte %h valid %b end %b status %0d",
                         $time, got.byte_value, got.byte_valid, got.packet_end, got.status);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got.byte_value !== want.byte_value)
                begin
                    $display("%0t: byte_value expected %h, got %h",
                             $time, want.byte_value, got.byte_value);
                    errors++;
                end
                if (got.byte_valid !== want.byte_valid)
                begin
                    $display("%0t: byte_valid expected %b, got %b",
                             $time, want.byte_valid, got.byte_valid);
                    errors++;
                end
                if (got.packet_end !== want.packet_end)
                begin
                    $display("%0t: packet_end expected %b, got %b",
                             $time, want.packet_end, got.packet_end);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: packet_status expected %0d, got %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Hard limit on the length of the run.
    initial
    begin
        #2_000_000;
        $display("pulse_duration_uart_frame_decoder_unit verification failed");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        pulse_ch.valid      = 1'b0;
        pulse_ch.low_ticks  = '0;
        pulse_ch.high_ticks = '0;
        pulse_ch.is_last    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_BIT_TICKS;
        cfg_ch.data         = '0;

        bit_ticks_r = RST_BIT_TICKS;
        offset_r    = RST_SAMPLE_OFFSET;
        max_r       = RST_MAX_BYTES;
        min_r       = RST_MIN_BYTES;
        edge_r      = 0;
        sample_r    = RST_SAMPLE_OFFSET;
        shift_r     = '0;
        nbits_r     = 0;
        nbytes_r    = '0;
        dropping_r  = 1'b0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_result_backlog();
        test_random_traffic();
        wait_drained();

        if (errors == 0)
            $display("pulse_duration_uart_frame_decoder_unit verification clean");
        else
            $display("pulse_duration_uart_frame_decoder_unit verification failed");
        $finish;
    end

endmodule
